/* rtl/core/ettcd_pkg.sv */
`timescale 1ns / 1ps

package ettcd_pkg;

    // Width of the elapsed-time input (36 to 48)
    localparam int TIME_BITS = 42;
    // Leftover milliseconds after the minute loop stay below 2^26
    localparam int MS_BITS   = 26;
    // Internal year wide enough for the widest time input
    localparam int YEAR_BITS = 14;
    localparam int C400_BITS = 9;

    localparam logic [YEAR_BITS-1:0] EPOCH_YEAR   = YEAR_BITS'(2000);
    localparam logic [3:0]           EPOCH_MONTH  = 4'd1;
    localparam logic [5:0]           EPOCH_DAY    = 6'd1;
    localparam logic [4:0]           EPOCH_HOUR   = 5'd11;
    localparam logic [5:0]           EPOCH_MINUTE = 6'd58;
    localparam logic [MS_BITS-1:0]   EPOCH_MS     = MS_BITS'(55816);

    localparam logic [C400_BITS-1:0] C400_LAST = C400_BITS'(399);

    localparam logic [TIME_BITS-1:0] SPAN_MIN  = TIME_BITS'(64'd60000);
    localparam logic [TIME_BITS-1:0] SPAN_HOUR = TIME_BITS'(64'd3600000);
    localparam logic [TIME_BITS-1:0] SPAN_DAY  = TIME_BITS'(64'd86400000);
    localparam logic [TIME_BITS-1:0] SPAN_D28  = TIME_BITS'(64'd2419200000);
    localparam logic [TIME_BITS-1:0] SPAN_D29  = TIME_BITS'(64'd2505600000);
    localparam logic [TIME_BITS-1:0] SPAN_D30  = TIME_BITS'(64'd2592000000);
    localparam logic [TIME_BITS-1:0] SPAN_D31  = TIME_BITS'(64'd2678400000);
    localparam logic [TIME_BITS-1:0] SPAN_Y365 = TIME_BITS'(64'd31536000000);
    localparam logic [TIME_BITS-1:0] SPAN_Y366 = TIME_BITS'(64'd31622400000);

    localparam logic [MS_BITS-1:0] MIN_MS = MS_BITS'(60000);

    // Running calendar value; c400 is the year modulo 400
    typedef struct packed {
        logic [YEAR_BITS-1:0] year;
        logic [C400_BITS-1:0] c400;
        logic [3:0]           month;
        logic [5:0]           day;
        logic [4:0]           hour;
        logic [5:0]           minute;
        logic [MS_BITS-1:0]   ms;
    } t_cal;

    // Gregorian rule on the year modulo 400
    function automatic logic leap_of(input logic [C400_BITS-1:0] c400);
        return (c400[1:0] == 2'd0) && (c400 != C400_BITS'(100))
            && (c400 != C400_BITS'(200)) && (c400 != C400_BITS'(300));
    endfunction

    function automatic logic [C400_BITS-1:0] c400_next(input logic [C400_BITS-1:0] c400);
        return (c400 == C400_LAST) ? '0 : c400 + C400_BITS'(1);
    endfunction

    function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
        logic [4:0] d;
        unique case (month)
            4'd2:                    d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            default:                 d = 5'd31;
        endcase
        return d;
    endfunction

    function automatic logic [TIME_BITS-1:0] month_span(input logic [4:0] days);
        logic [TIME_BITS-1:0] s;
        unique case (days)
            5'd28:   s = SPAN_D28;
            5'd29:   s = SPAN_D29;
            5'd30:   s = SPAN_D30;
            default: s = SPAN_D31;
        endcase
        return s;
    endfunction

endpackage

/* rtl/core/ettcd_sub.sv */
`timescale 1ns / 1ps

module ettcd_sub
    import ettcd_pkg::*;
(
    input  logic [TIME_BITS-1:0] i_a,
    input  logic [TIME_BITS-1:0] i_b,
    output logic [TIME_BITS-1:0] o_diff,
    output logic                 o_gt
);

    logic [TIME_BITS:0] wide;

    // Subtract once; borrow and zero test give the strict compare
    assign wide   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = wide[TIME_BITS-1:0];
    assign o_gt   = !wide[TIME_BITS] && (wide[TIME_BITS-1:0] != '0);

endmodule

/* rtl/core/ettcd_norm.sv */
`timescale 1ns / 1ps

module ettcd_norm
    import ettcd_pkg::*;
(
    input  t_cal i_cal,
    output t_cal o_cal,
    output logic o_done
);

    logic f_ms, f_min, f_hour, f_day, f_mon;

    // One carry pass: each field moves by at most one unit, in order
    always_comb begin
        o_cal = i_cal;

        f_ms = (o_cal.ms >= MIN_MS);
        if (f_ms) begin
            o_cal.ms     = o_cal.ms - MIN_MS;
            o_cal.minute = o_cal.minute + 6'd1;
        end

        f_min = (o_cal.minute >= 6'd60);
        if (f_min) begin
            o_cal.minute = o_cal.minute - 6'd60;
            o_cal.hour   = o_cal.hour + 5'd1;
        end

        f_hour = (o_cal.hour >= 5'd24);
        if (f_hour) begin
            o_cal.hour = o_cal.hour - 5'd24;
            o_cal.day  = o_cal.day + 6'd1;
        end

        f_day = (o_cal.day > {1'b0, month_days(leap_of(o_cal.c400), o_cal.month)});
        if (f_day) begin
            o_cal.day   = 6'd1;
            o_cal.month = o_cal.month + 4'd1;
        end

        f_mon = (o_cal.month > 4'd12);
        if (f_mon) begin
            o_cal.month = 4'd1;
            o_cal.year  = o_cal.year + YEAR_BITS'(1);
            o_cal.c400  = c400_next(o_cal.c400);
        end

        o_done = !(f_ms || f_min || f_hour || f_day || f_mon);
    end

endmodule

/* rtl/core/elapsed_time_to_calendar_date_unit.sv */
`timescale 1ns / 1ps
// Channel  Ports                                   Handshake
// -------  --------------------------------------  ---------------------------------
// in       i_elapsed_ms                            beat taken when start && !busy
// out      o_year o_month o_day o_hour o_minute    beat shown for one cycle with
//          o_milli_of_minute                       o_valid; the receiver cannot stall
//
// One beat runs from the accepting edge to the strobe: years, months, days,
// hours and minutes are peeled off one per cycle through the shared
// subtract/compare unit, each loop leaving once its test fails, then carry
// passes run one a cycle, the last one finding nothing to carry. busy is high
// from accept until the strobe. Synchronous active-low reset returns the
// sequencer to idle and drops o_valid.

module elapsed_time_to_calendar_date_unit
    import ettcd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [TIME_BITS-1:0] i_elapsed_ms,
    output logic                 o_valid,
    output logic [11:0]          o_year,
    output logic [3:0]           o_month,
    output logic [4:0]           o_day,
    output logic [4:0]           o_hour,
    output logic [5:0]           o_minute,
    output logic [15:0]          o_milli_of_minute
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MINUTE,
        ST_NORM
    } t_state;

    t_state               r_state, n_state;
    logic                 r_valid, n_valid;
    logic [TIME_BITS-1:0] r_t, n_t;
    t_cal                 r_cal, n_cal;

    logic [TIME_BITS-1:0] span, diff;
    logic                 gt;
    logic                 lp;
    logic [4:0]           last;
    t_cal                 norm_cal;
    logic                 norm_done;

    // Leap flag and month length of the current year and month
    assign lp   = leap_of(r_cal.c400);
    assign last = month_days(lp, r_cal.month);

    // Select the span to test against
    always_comb begin
        unique case (r_state)
            ST_YEAR:  span = lp ? SPAN_Y366 : SPAN_Y365;
            ST_MONTH: span = month_span(last);
            ST_DAY:   span = SPAN_DAY;
            ST_HOUR:  span = SPAN_HOUR;
            default:  span = SPAN_MIN;
        endcase
    end

    ettcd_sub u_sub (
        .i_a    (r_t),
        .i_b    (span),
        .o_diff (diff),
        .o_gt   (gt)
    );

    ettcd_norm u_norm (
        .i_cal  (r_cal),
        .o_cal  (norm_cal),
        .o_done (norm_done)
    );

    // Sequence the peel loops and the carry passes
    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_t     = r_t;
        n_cal   = r_cal;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_t          = i_elapsed_ms;
                    n_cal.year   = EPOCH_YEAR;
                    n_cal.c400   = '0;
                    n_cal.month  = EPOCH_MONTH;
                    n_cal.day    = EPOCH_DAY;
                    n_cal.hour   = EPOCH_HOUR;
                    n_cal.minute = EPOCH_MINUTE;
                    n_cal.ms     = EPOCH_MS;
                    n_state      = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (gt) begin
                    n_t        = diff;
                    n_cal.year = r_cal.year + YEAR_BITS'(1);
                    n_cal.c400 = c400_next(r_cal.c400);
                end else begin
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (gt && (r_cal.month < 4'd12)) begin
                    n_t         = diff;
                    n_cal.month = r_cal.month + 4'd1;
                end else begin
                    n_state = ST_DAY;
                end
            end
            ST_DAY: begin
                if (gt && (r_cal.day < {1'b0, last})) begin
                    n_t       = diff;
                    n_cal.day = r_cal.day + 6'd1;
                end else begin
                    n_state = ST_HOUR;
                end
            end
            ST_HOUR: begin
                if (gt && (r_cal.hour < 5'd23)) begin
                    n_t        = diff;
                    n_cal.hour = r_cal.hour + 5'd1;
                end else begin
                    n_state = ST_MINUTE;
                end
            end
            ST_MINUTE: begin
                if (gt && (r_cal.minute < 6'd59)) begin
                    n_t          = diff;
                    n_cal.minute = r_cal.minute + 6'd1;
                end else begin
                    n_cal.ms = EPOCH_MS + r_t[MS_BITS-1:0];
                    n_state  = ST_NORM;
                end
            end
            ST_NORM: begin
                n_cal = norm_cal;
                if (norm_done) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state, strobe and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_t   <= n_t;
        r_cal <= n_cal;
    end

    assign busy              = (r_state != ST_IDLE);
    assign o_valid           = r_valid;
    assign o_year            = r_cal.year[11:0];
    assign o_month           = r_cal.month;
    assign o_day             = r_cal.day[4:0];
    assign o_hour            = r_cal.hour;
    assign o_minute          = r_cal.minute;
    assign o_milli_of_minute = r_cal.ms[15:0];

endmodule

/* sim/elapsed_time_to_calendar_date_unit_test.sv */
`timescale 1ns / 1ps

module elapsed_time_to_calendar_date_unit_test;
    import ettcd_pkg::*;

    localparam longint unsigned MS_MIN  = 64'd60000;
    localparam longint unsigned MS_HOUR = 64'd3600000;
    localparam longint unsigned MS_DAY  = 64'd86400000;

    // Worst beat is dominated by the carry passes rather than by the peeling
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int TAIL_CYCLES     = 1100;
    localparam int BEATS_PER_PHASE = 517;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] milli;
    } cal_date_t;

    // Expected calendar dates, one per accepted elapsed time
    class calendar_scoreboard;
        cal_date_t   expected_dates[$];
        int unsigned failures;

        static function bit is_leap(int unsigned yr);
            if (yr % 100 != 0) return (yr % 4 == 0);
            return (yr % 400 == 0);
        endfunction

        static function int unsigned days_in(int unsigned yr, int unsigned mon);
            case (mon)
                2:           return 28 + is_leap(yr);
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        // Peel years, months, days, hours and minutes with strict tests, then carry
        static function cal_date_t calendar_of(logic [TIME_BITS-1:0] elapsed);
            longint unsigned rest;
            longint unsigned span;
            longint unsigned ms;
            int unsigned     yr;
            int unsigned     mon;
            int unsigned     dy;
            int unsigned     hr;
            int unsigned     mn;
            int unsigned     last;
            bit              settled;
            cal_date_t       r;
            rest = elapsed;
            yr   = 2000;
            mon  = 1;
            dy   = 1;
            hr   = 11;
            mn   = 58;
            ms   = 55816;
            span = MS_DAY * (365 + is_leap(yr));
            while (rest > span) begin
                yr++;
                rest -= span;
                span = MS_DAY * (365 + is_leap(yr));
            end
            span = MS_DAY * days_in(yr, mon);
            while (rest > span && mon < 12) begin
                mon++;
                rest -= span;
                span = MS_DAY * days_in(yr, mon);
            end
            last = days_in(yr, mon);
            while (rest > MS_DAY && dy < last) begin
                dy++;
                rest -= MS_DAY;
            end
            while (rest > MS_HOUR && hr < 23) begin
                hr++;
                rest -= MS_HOUR;
            end
            while (rest > MS_MIN && mn < 59) begin
                mn++;
                rest -= MS_MIN;
            end
            ms += rest;
            // Carry at most one unit per field per pass
            do begin
                settled = 1'b1;
                if (ms >= MS_MIN) begin
                    ms -= MS_MIN;
                    mn++;
                    settled = 1'b0;
                end
                if (mn >= 60) begin
                    mn -= 60;
                    hr++;
                    settled = 1'b0;
                end
                if (hr >= 24) begin
                    hr -= 24;
                    dy++;
                    settled = 1'b0;
                end
                if (dy > days_in(yr, (mon >= 1 && mon <= 12) ? mon : 12)) begin
                    dy = 1;
                    mon++;
                    settled = 1'b0;
                end
                if (mon > 12) begin
                    mon = 1;
                    yr++;
                    settled = 1'b0;
                end
            end while (!settled);
            r.year   = 12'(yr);
            r.month  = 4'(mon);
            r.day    = 5'(dy);
            r.hour   = 5'(hr);
            r.minute = 6'(mn);
            r.milli  = 16'(ms);
            return r;
        endfunction

        function void note_elapsed(logic [TIME_BITS-1:0] elapsed);
            expected_dates.push_back(calendar_of(elapsed));
        endfunction

        function void compare_field(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_date(cal_date_t got);
            cal_date_t want;
            if (expected_dates.size() == 0) begin
                $error("result beat with no elapsed time pending");
                failures++;
                return;
            end
            want = expected_dates.pop_front();
            compare_field("year", want.year, got.year);
            compare_field("month", want.month, got.month);
            compare_field("day", want.day, got.day);
            compare_field("hour", want.hour, got.hour);
            compare_field("minute", want.minute, got.minute);
            compare_field("milli_of_minute", want.milli, got.milli);
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic [TIME_BITS-1:0] i_elapsed_ms = '0;
    logic                 busy;
    logic                 o_valid;
    logic [11:0]          o_year;
    logic [3:0]           o_month;
    logic [4:0]           o_day;
    logic [4:0]           o_hour;
    logic [5:0]           o_minute;
    logic [15:0]          o_milli_of_minute;

    calendar_scoreboard calendar_check = new();
    longint unsigned    year_start_ms[0:140];
    int                 quiet_cycles   = 0;

    elapsed_time_to_calendar_date_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_elapsed_ms     (i_elapsed_ms),
        .o_valid          (o_valid),
        .o_year           (o_year),
        .o_month          (o_month),
        .o_day            (o_day),
        .o_hour           (o_hour),
        .o_minute         (o_minute),
        .o_milli_of_minute(o_milli_of_minute)
    );

    always #6 i_clk = ~i_clk;

    // Note accepted beats, check result beats, and trip the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) calendar_check.note_elapsed(i_elapsed_ms);
            if (o_valid) begin
                calendar_check.check_date('{o_year, o_month, o_day, o_hour, o_minute,
                                            o_milli_of_minute});
            end
            if ((start && !busy) || o_valid) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Hold start low for idle cycles, then present one beat until it is taken
    task automatic send_elapsed(input logic [TIME_BITS-1:0] value, input int unsigned idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_elapsed_ms <= value;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and hold off until every expected date has come back
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (calendar_check.pending() != 0) @(posedge i_clk);
    endtask

    // Half calendar boundaries with random offsets, the rest full-range noise or the first three days
    function automatic logic [TIME_BITS-1:0] pick_elapsed();
        longint unsigned v;
        int unsigned     yr_idx;
        int unsigned     mon_idx;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = {$urandom, $urandom};
            4:          v = $urandom_range(0, 32'd259200000);
            default: begin
                yr_idx  = $urandom_range(0, 139);
                mon_idx = $urandom_range(0, 11);
                v       = year_start_ms[yr_idx];
                for (int m = 1; m <= mon_idx; m++)
                    v += MS_DAY * calendar_scoreboard::days_in(2000 + yr_idx, m);
                if ($urandom_range(0, 1)) v += MS_DAY * $urandom_range(0, 30);
                if ($urandom_range(0, 1)) v += MS_HOUR * $urandom_range(0, 23);
                if ($urandom_range(0, 1)) v += MS_MIN * $urandom_range(0, 59);
                case ($urandom_range(0, 3))
                    0:       v -= 1;
                    1:       v += 1;
                    2:       v += $urandom_range(0, 59999);
                    default: ;
                endcase
            end
        endcase
        return TIME_BITS'(v);
    endfunction

    task automatic run_phase(input int unsigned idle_pct);
        repeat (BEATS_PER_PHASE) send_elapsed(pick_elapsed(), idle_pct);
        wait_for_results();
    endtask

    initial begin
        longint unsigned directed_ms[$];
        year_start_ms[0] = 0;
        for (int k = 1; k <= 140; k++)
            year_start_ms[k] = year_start_ms[k-1]
                + MS_DAY * (365 + calendar_scoreboard::is_leap(2000 + k - 1));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero, epoch carry edges, exact unit boundaries, leap and century years, extremes
        directed_ms = '{0, 1, 4183, 4184, 4185, MS_MIN, MS_MIN + 1, MS_HOUR, MS_HOUR + 1,
                        MS_DAY, MS_DAY + 1, 31 * MS_DAY, 59 * MS_DAY + 1, 60 * MS_DAY,
                        year_start_ms[1], year_start_ms[1] + 1, year_start_ms[100],
                        year_start_ms[100] + 58 * MS_DAY + 1,
                        year_start_ms[100] + 59 * MS_DAY + 1, year_start_ms[139],
                        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                        64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF};
        foreach (directed_ms[n]) send_elapsed(TIME_BITS'(directed_ms[n]), 0);
        wait_for_results();

        run_phase(37);
        run_phase(66);
        run_phase(0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (calendar_check.failures == 0 && calendar_check.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
